>>> rtl/core/run_limited_binary_sequence_count_assert.svh
// Assertion helpers for the sequence-count core.
// Both expect clk and rst_n in scope.
`ifndef RUN_LIMITED_BINARY_SEQUENCE_COUNT_ASSERT_SVH
`define RUN_LIMITED_BINARY_SEQUENCE_COUNT_ASSERT_SVH

// same-cycle implication
`define RLBSC_AP_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLBSC_AP_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rlbsc_pkg.sv
`default_nettype none

package rlbsc_pkg;

    localparam int MAX_COUNT = 127;
    localparam int FIELD_W   = 7;
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int CMP_W     = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int ADDR_W    = 2 * CNT_W + 1;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int VAL_W     = 30;

    localparam logic [VAL_W-1:0] SEQ_MOD = 30'd1000000007;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        val_t  data;
    } tbl_wr_t;

    // saturate a request count to the table bound
    function automatic cnt_t clamp_cnt(input logic [FIELD_W-1:0] x);
        cnt_t r;
        if (CMP_W'(x) > CMP_W'(MAX_COUNT))
            r = CNT_W'(MAX_COUNT);
        else
            r = CNT_W'(x);
        return r;
    endfunction

    // number of terms in one windowed sum: min(count, limit)
    function automatic cnt_t min_cnt(input cnt_t c, input logic [FIELD_W-1:0] lim);
        cnt_t r;
        if (CMP_W'(lim) < CMP_W'(c))
            r = CNT_W'(lim);
        else
            r = c;
        return r;
    endfunction

    // entry (ones left, zeros left, last symbol)
    function automatic addr_t tbl_addr(input cnt_t o, input cnt_t z, input logic s);
        return {o, z, s};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/run_limited_binary_sequence_count.sv
// Channel    | Signals                                | Transfer
// -----------+----------------------------------------+-------------------------
// request    | start, busy, zero_total, one_total,    | edge with start & !busy
//            | run_limit                              |
// result     | done, sequence_count                   | edge ending the done cycle
//
// One modular adder and one table read port do all the work. Each table
// cell (o, z) takes min(z, limit) + min(o, limit) reads, one read per
// summed term, besides steps ADV and SETUP and one write per half;
// done rises in the same cycle that busy drops.
// Both counts zero: result in the cycle after the transfer, busy stays low.
// Reset clears the sequencer only; the table is filled before it is read.
// The result strobe lasts one cycle and cannot be held off.
`default_nettype none

`include "run_limited_binary_sequence_count_assert.svh"

module run_limited_binary_sequence_count (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire [rlbsc_pkg::FIELD_W-1:0]       zero_total,
    input  wire [rlbsc_pkg::FIELD_W-1:0]       one_total,
    input  wire [rlbsc_pkg::FIELD_W-1:0]       run_limit,
    output logic                               done,
    output logic [rlbsc_pkg::VAL_W-1:0]        sequence_count
);

    typedef enum logic [3:0] {
        IDLE,
        BASE0,
        BASE1,
        ADV,
        SETUP,
        RUN,
        FIN_A,
        FIN_B,
        FIN_C
    } state_t;

    state_t                          state_reg, state_next;
    rlbsc_pkg::cnt_t                 ones_reg, ones_next;
    rlbsc_pkg::cnt_t                 zeros_reg, zeros_next;
    logic [rlbsc_pkg::FIELD_W-1:0]   limit_reg, limit_next;
    rlbsc_pkg::cnt_t                 o_reg, o_next;
    rlbsc_pkg::cnt_t                 z_reg, z_next;
    rlbsc_pkg::cnt_t                 len_reg, len_next;
    rlbsc_pkg::cnt_t                 rem_reg, rem_next;
    logic                            half_reg, half_next;
    logic                            pend_reg, pend_next;
    rlbsc_pkg::val_t                 acc_reg, acc_next;
    rlbsc_pkg::val_t                 count_reg, count_next;
    logic                            done_reg, done_next;

    rlbsc_pkg::tbl_wr_t              tbl_wr;
    logic                            rd_en;
    rlbsc_pkg::addr_t                rd_addr;
    rlbsc_pkg::val_t                 rd_data;
    rlbsc_pkg::val_t                 sum;
    rlbsc_pkg::cnt_t                 req_zeros;
    rlbsc_pkg::cnt_t                 req_ones;

    rlbsc_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rlbsc_addmod u_addmod (
        .a   (acc_reg),
        .b   (rd_data),
        .sum (sum)
    );

    assign req_zeros = rlbsc_pkg::clamp_cnt(zero_total);
    assign req_ones  = rlbsc_pkg::clamp_cnt(one_total);

    always_comb
    begin
        state_next = state_reg;
        ones_next  = ones_reg;
        zeros_next = zeros_reg;
        limit_next = limit_reg;
        o_next     = o_reg;
        z_next     = z_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        half_next  = half_reg;
        pend_next  = 1'b0;
        acc_next   = acc_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        tbl_wr     = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;

        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    ones_next  = req_ones;
                    zeros_next = req_zeros;
                    limit_next = run_limit;
                    o_next     = '0;
                    z_next     = '0;
                    if (req_ones == '0 && req_zeros == '0)
                    begin
                        // empty sequence: exactly one
                        count_next = rlbsc_pkg::VAL_W'(1);
                        done_next  = 1'b1;
                    end
                    else
                        state_next = BASE0;
                end
            end
            BASE0:
            begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = rlbsc_pkg::tbl_addr('0, '0, 1'b0);
                tbl_wr.data = rlbsc_pkg::VAL_W'(1);
                state_next  = BASE1;
            end
            BASE1:
            begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = rlbsc_pkg::tbl_addr('0, '0, 1'b1);
                tbl_wr.data = rlbsc_pkg::VAL_W'(1);
                state_next  = ADV;
            end
            ADV:
            begin
                if (z_reg == zeros_reg)
                begin
                    if (o_reg == ones_reg)
                        state_next = FIN_A;
                    else
                    begin
                        o_next     = o_reg + 1'b1;
                        z_next     = '0;
                        state_next = SETUP;
                    end
                end
                else
                begin
                    z_next     = z_reg + 1'b1;
                    state_next = SETUP;
                end
            end
            SETUP:
            begin
                rem_next   = rlbsc_pkg::min_cnt(z_reg, limit_reg);
                len_next   = rlbsc_pkg::CNT_W'(1);
                acc_next   = '0;
                half_next  = 1'b1;
                state_next = RUN;
            end
            RUN:
            begin
                if (rem_reg != '0)
                begin
                    // issue one read; fold in the one that just returned
                    rd_en = 1'b1;
                    if (half_reg)
                        rd_addr = rlbsc_pkg::tbl_addr(o_reg, z_reg - len_reg, 1'b0);
                    else
                        rd_addr = rlbsc_pkg::tbl_addr(o_reg - len_reg, z_reg, 1'b1);
                    len_next  = len_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    pend_next = 1'b1;
                    if (pend_reg)
                        acc_next = sum;
                end
                else
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = rlbsc_pkg::tbl_addr(o_reg, z_reg, half_reg);
                    tbl_wr.data = pend_reg ? sum : acc_reg;
                    if (half_reg)
                    begin
                        half_next = 1'b0;
                        rem_next  = rlbsc_pkg::min_cnt(o_reg, limit_reg);
                        len_next  = rlbsc_pkg::CNT_W'(1);
                        acc_next  = '0;
                    end
                    else
                        state_next = ADV;
                end
            end
            FIN_A:
            begin
                rd_en      = 1'b1;
                rd_addr    = rlbsc_pkg::tbl_addr(ones_reg, zeros_reg, 1'b0);
                state_next = FIN_B;
            end
            FIN_B:
            begin
                rd_en      = 1'b1;
                rd_addr    = rlbsc_pkg::tbl_addr(ones_reg, zeros_reg, 1'b1);
                acc_next   = rd_data;
                state_next = FIN_C;
            end
            FIN_C:
            begin
                count_next = sum;
                done_next  = 1'b1;
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ones_reg  <= '0;
            zeros_reg <= '0;
            limit_reg <= '0;
            o_reg     <= '0;
            z_reg     <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            half_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            acc_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ones_reg  <= ones_next;
            zeros_reg <= zeros_next;
            limit_reg <= limit_next;
            o_reg     <= o_next;
            z_reg     <= z_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            half_reg  <= half_next;
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign busy           = (state_reg != IDLE);
    assign done           = done_reg;
    assign sequence_count = count_reg;

    `RLBSC_AP_NOW(a_done_idle, done_reg, state_reg == IDLE,
        "result strobe while sequencer is active")
    `RLBSC_AP_NOW(a_no_rw_clash, tbl_wr.en, !rd_en,
        "table write and read issued in the same cycle")
    `RLBSC_AP_NEXT(a_start_acts, start && !busy, busy || done_reg,
        "accepted request neither started nor answered")
    `RLBSC_AP_NOW(a_zero_window, state_reg == RUN && half_reg && rem_reg != '0,
        len_reg <= z_reg, "zero-run read below column zero")

endmodule

`default_nettype wire

>>> rtl/core/rlbsc_addmod.sv
`default_nettype none

// Shared modular adder: both operands below the modulus.
module rlbsc_addmod (
    input  wire rlbsc_pkg::val_t a,
    input  wire rlbsc_pkg::val_t b,
    output rlbsc_pkg::val_t      sum
);

    logic [rlbsc_pkg::VAL_W:0] raw;
    logic [rlbsc_pkg::VAL_W:0] mod_ext;

    assign mod_ext = {1'b0, rlbsc_pkg::SEQ_MOD};
    assign raw     = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        if (raw >= mod_ext)
            sum = rlbsc_pkg::VAL_W'(raw - mod_ext);
        else
            sum = rlbsc_pkg::VAL_W'(raw);
    end

endmodule

`default_nettype wire

>>> rtl/core/rlbsc_table.sv
`default_nettype none

// Partial-count store: one write port, one registered read port.
module rlbsc_table (
    input  wire                     clk,
    input  wire rlbsc_pkg::tbl_wr_t wr,
    input  wire                     rd_en,
    input  wire rlbsc_pkg::addr_t   rd_addr,
    output rlbsc_pkg::val_t         rd_data
);

    rlbsc_pkg::val_t mem [rlbsc_pkg::DEPTH];
    rlbsc_pkg::val_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
